// ===== rtl/bsmd_pkg.sv =====
// Package for the bit-serial message deframer.
// Holds the result transaction type and the status codes; no dependencies.
`default_nettype none

package bsmd_pkg;

    localparam int SENDER_BITS = 32;
    localparam int BYTE_BITS   = 8;
    localparam int WORD_BITS   = 32;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_COLLISION = 2'd1;
    localparam logic [1:0] STATUS_HALTED    = 2'd2;

    typedef struct packed {
        logic                 ack;
        logic                 byte_valid;
        logic [BYTE_BITS-1:0] byte_value;
        logic [WORD_BITS-1:0] byte_index;
        logic                 in_range;
        logic [WORD_BITS-1:0] message_length;
        logic [WORD_BITS-1:0] sender_id;
        logic [1:0]           status;
        logic                 last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/bit_serial_message_deframer.sv =====
// Bit-serial message deframer top level: header capture, sender check,
// byte assembly and a two-entry output stage. Depends on bsmd_pkg.
//
// Throughput: one bit per cycle while in_stall is low; the frame state
// updates in the accept cycle, so the next-state logic (32-bit compares
// on length, count, id) sets it. Results are registered in the output
// register, and one skid entry holds a result behind a stalled output.
// Reset: rst_n clears all frame state and min_sender_id; only reset restarts.
`default_nettype none

module bit_serial_message_deframer
    import bsmd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [WORD_BITS-1:0] cfg_wr_data,

    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 bit_value,

    // output channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      ack,
    output logic                      byte_valid,
    output logic [BYTE_BITS-1:0]      byte_value,
    output logic [WORD_BITS-1:0]      byte_index,
    output logic                      in_range,
    output logic [WORD_BITS-1:0]      message_length,
    output logic [WORD_BITS-1:0]      sender_id,
    output logic [1:0]                status,
    output logic                      last
);

    // hdr_count_reg marks: end of length field, end of header, sender checked
    localparam logic [6:0] LEN_END = 7'(LENGTH_BITS);
    localparam logic [6:0] HDR_END = 7'(LENGTH_BITS + SENDER_BITS);
    localparam logic [6:0] CHECKED = 7'(LENGTH_BITS + SENDER_BITS + 1);

    // frame state
    logic [WORD_BITS-1:0]   min_sender_id_reg;
    logic [6:0]             hdr_count_reg, hdr_count_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic [SENDER_BITS-1:0] sender_reg, sender_next;
    logic [BYTE_BITS-1:0]   byte_shift_reg, byte_shift_next;
    logic [2:0]             bit_in_byte_reg, bit_in_byte_next;
    logic [WORD_BITS-1:0]   bytes_rcvd_reg, bytes_rcvd_next;
    logic                   collision_reg, collision_next;
    logic                   halted_reg, halted_next;

    // output stage
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    result_t                out_reg;
    result_t                skid_reg;
    result_t                res;

    logic accept;
    logic take;
    logic out_free;

    logic [WORD_BITS-1:0]   len_ext;
    logic [BYTE_BITS-1:0]   shifted;

    assign accept   = in_valid && !in_stall;
    assign take     = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || take;
    // stall only while the skid entry is occupied
    assign in_stall = skid_valid_reg;

    assign len_ext = WORD_BITS'(length_reg);
    assign shifted = {byte_shift_reg[BYTE_BITS-2:0], bit_value};

    // Next frame state and the result for the bit on the input.
    always_comb
    begin
        hdr_count_next   = hdr_count_reg;
        length_next      = length_reg;
        sender_next      = sender_reg;
        byte_shift_next  = byte_shift_reg;
        bit_in_byte_next = bit_in_byte_reg;
        bytes_rcvd_next  = bytes_rcvd_reg;
        collision_next   = collision_reg;
        halted_next      = halted_reg;

        res            = '0;

        if (!halted_reg)
        begin
            // collision check comes first on every live bit, header bits too
            if (bytes_rcvd_reg > len_ext && len_ext != '0)
            begin
                collision_next = 1'b1;
            end

            if (hdr_count_reg < LEN_END)
            begin
                length_next    = {length_reg[LENGTH_BITS-2:0], bit_value};
                hdr_count_next = hdr_count_reg + 7'd1;
            end
            else if (hdr_count_reg < HDR_END)
            begin
                sender_next    = {sender_reg[SENDER_BITS-2:0], bit_value};
                hdr_count_next = hdr_count_reg + 7'd1;
            end
            else if (hdr_count_reg == HDR_END && sender_reg < min_sender_id_reg)
            begin
                // rejected sender: this bit is dropped and the receiver stops
                hdr_count_next = CHECKED;
                halted_next    = 1'b1;
            end
            else
            begin
                hdr_count_next = CHECKED;
                if (bit_in_byte_reg == 3'd7)
                begin
                    res.byte_valid = 1'b1;
                    res.byte_value = shifted;
                    res.byte_index = bytes_rcvd_reg;
                    res.in_range   = bytes_rcvd_reg < len_ext;
                    res.last       = (len_ext != '0) &&
                                     (bytes_rcvd_reg == len_ext - WORD_BITS'(1));
                    if (bytes_rcvd_reg != '1)
                    begin
                        bytes_rcvd_next = bytes_rcvd_reg + WORD_BITS'(1);
                    end
                    byte_shift_next  = '0;
                    bit_in_byte_next = 3'd0;
                end
                else
                begin
                    byte_shift_next  = shifted;
                    bit_in_byte_next = bit_in_byte_reg + 3'd1;
                end
                res.ack = !collision_next || (len_ext == '0);
            end
        end

        res.message_length = WORD_BITS'(length_next);
        res.sender_id      = sender_next;
        if (halted_next)
        begin
            res.status = STATUS_HALTED;
        end
        else if (collision_next)
        begin
            res.status = STATUS_COLLISION;
        end
        else
        begin
            res.status = STATUS_OK;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sender_id_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            min_sender_id_reg <= cfg_wr_data;
        end
    end

    // frame state advances once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg   <= '0;
            length_reg      <= '0;
            sender_reg      <= '0;
            byte_shift_reg  <= '0;
            bit_in_byte_reg <= '0;
            bytes_rcvd_reg  <= '0;
            collision_reg   <= 1'b0;
            halted_reg      <= 1'b0;
        end
        else if (accept)
        begin
            hdr_count_reg   <= hdr_count_next;
            length_reg      <= length_next;
            sender_reg      <= sender_next;
            byte_shift_reg  <= byte_shift_next;
            bit_in_byte_reg <= bit_in_byte_next;
            bytes_rcvd_reg  <= bytes_rcvd_next;
            collision_reg   <= collision_next;
            halted_reg      <= halted_next;
        end
    end

    // output / skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output / skid payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ack            = out_reg.ack;
    assign byte_valid     = out_reg.byte_valid;
    assign byte_value     = out_reg.byte_value;
    assign byte_index     = out_reg.byte_index;
    assign in_range       = out_reg.in_range;
    assign message_length = out_reg.message_length;
    assign sender_id      = out_reg.sender_id;
    assign status         = out_reg.status;
    assign last           = out_reg.last;

`ifndef SYNTH
    // halt is permanent until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    // skid entry only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // collision can only latch against a nonzero length
    a_collision_len: assert property (@(posedge clk) disable iff (!rst_n)
        collision_reg |-> (length_reg != '0))
        else $error("collision latched with zero length");

    // a halted result never acknowledges or carries a byte
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == STATUS_HALTED)
            |-> (!out_reg.ack && !out_reg.byte_valid))
        else $error("halted result with ack or byte");
`endif

endmodule

`default_nettype wire
